// ----- hw/rtl/mvsm_pkg.sv -----
// Shared types, command codes and constants of the sample playback mixer.
package mvsm_pkg;

    // Default sizes handed down to the modules.
    localparam int DEF_NUM_SOUNDS  = 16;
    localparam int DEF_SOUND_WORDS = 4096;
    localparam int DEF_MAX_VOICES  = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed widths of the ports.
    localparam int SMP_W    = 16;
    localparam int VOL_W    = 16;
    localparam int FPB_W    = 13;
    localparam int FRAME_W  = 12;
    localparam int ACTIVE_W = 5;

    // Gain is unsigned Q1.15; results are rounded half up before the shift.
    localparam int VOL_FRAC = 15;
    localparam int RND_BIAS = 1 << (VOL_FRAC - 1);

    localparam logic [VOL_W-1:0] VOLUME_RESET = 16'd32768;
    localparam logic [FPB_W-1:0] FPB_RESET    = 13'd256;
    localparam logic [FPB_W-1:0] FPB_MAX      = 13'd4096;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_LENGTH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_CLIP = 2'd2
    } t_status;

    typedef enum logic {
        CFG_VOLUME = 1'b0,
        CFG_FPB    = 1'b1
    } t_cfg_idx;

    // Controls of the sample and length memories.
    typedef struct packed {
        logic rd;
        logic smp_wr;
        logic len_wr;
    } t_mem_ctrl;

    // Controls of the voice table.
    typedef struct packed {
        logic claim;
        logic advance;
        logic release_v;
        logic stop;
    } t_voice_ctrl;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul;
        logic sel_right;
        logic acc_left;
        logic acc_right;
    } t_mac_ctrl;

endpackage

// ----- hw/rtl/mvsm_sample_mem.sv -----
// Sample store and per-slot length memory, with the length clearing pass after reset.
module mvsm_sample_mem
    import mvsm_pkg::*;
#(
    parameter int NUM_SOUNDS  = DEF_NUM_SOUNDS,
    parameter int SOUND_WORDS = DEF_SOUND_WORDS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_mem_ctrl                             i_ctrl,
    input  logic [$clog2(2*NUM_SOUNDS)-1:0]       i_wr_slot,
    input  logic [$clog2(SOUND_WORDS)-1:0]        i_wr_pos,
    input  logic [2*SMP_W-1:0]                    i_smp_wdata,
    input  logic [$clog2(SOUND_WORDS+1)-1:0]      i_len_wdata,
    input  logic [$clog2(2*NUM_SOUNDS)-1:0]       i_rd_slot,
    input  logic [$clog2(SOUND_WORDS)-1:0]        i_rd_pos,
    output logic [2*SMP_W-1:0]                    o_smp_rdata,
    output logic [$clog2(SOUND_WORDS+1)-1:0]      o_len_rdata,
    output logic                                  o_busy
);

    localparam int NSLOTS = 2 * NUM_SOUNDS;
    localparam int SLW    = $clog2(NSLOTS);
    localparam int LW     = $clog2(SOUND_WORDS + 1);
    localparam int DEPTH  = NSLOTS * SOUND_WORDS;
    localparam int SAW    = $clog2(DEPTH);

    logic [2*SMP_W-1:0] r_smp_mem [DEPTH];
    logic [LW-1:0]      r_len_mem [NSLOTS];

    logic [2*SMP_W-1:0] r_smp_rdata;
    logic [LW-1:0]      r_len_rdata;
    logic [SLW-1:0]     r_clr_idx;
    logic               r_busy;

    logic [SAW-1:0] wr_addr;
    logic [SAW-1:0] rd_addr;

    assign wr_addr = SAW'(i_wr_slot) * SAW'(SOUND_WORDS) + SAW'(i_wr_pos);
    assign rd_addr = SAW'(i_rd_slot) * SAW'(SOUND_WORDS) + SAW'(i_rd_pos);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.smp_wr) begin
            r_smp_mem[wr_addr] <= i_smp_wdata;
        end
        if (i_ctrl.rd) begin
            r_smp_rdata <= r_smp_mem[rd_addr];
        end
    end

    // The length memory is swept to zero once after reset, one slot a cycle.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_len_mem[r_clr_idx] <= '0;
        end else if (i_ctrl.len_wr) begin
            r_len_mem[i_wr_slot] <= i_len_wdata;
        end
        if (i_ctrl.rd) begin
            r_len_rdata <= r_len_mem[i_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            if (r_clr_idx == SLW'(NSLOTS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign o_smp_rdata = r_smp_rdata;
    assign o_len_rdata = r_len_rdata;
    assign o_busy      = r_busy;

endmodule

// ----- hw/rtl/mvsm_voice_tbl.sv -----
// Voice table: slot and position memory, active flags and the count of playing voices.
module mvsm_voice_tbl
    import mvsm_pkg::*;
#(
    parameter int NUM_SOUNDS  = DEF_NUM_SOUNDS,
    parameter int SOUND_WORDS = DEF_SOUND_WORDS,
    parameter int MAX_VOICES  = DEF_MAX_VOICES
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  t_voice_ctrl                                   i_ctrl,
    input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] i_idx,
    input  logic [$clog2(2*NUM_SOUNDS)-1:0]               i_wr_slot,
    input  logic [$clog2(SOUND_WORDS)-1:0]                i_wr_pos,
    output logic                                          o_idx_active,
    output logic [$clog2(2*NUM_SOUNDS)-1:0]               o_rd_slot,
    output logic [$clog2(SOUND_WORDS)-1:0]                o_rd_pos,
    output logic [$clog2(MAX_VOICES+1)-1:0]               o_count
);

    localparam int SLW  = $clog2(2 * NUM_SOUNDS);
    localparam int PW   = $clog2(SOUND_WORDS);
    localparam int CNTW = $clog2(MAX_VOICES + 1);

    logic [SLW+PW-1:0] r_mem [MAX_VOICES];
    logic [SLW+PW-1:0] r_rdata;
    logic              r_active [MAX_VOICES];
    logic [CNTW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.claim || i_ctrl.advance) begin
            r_mem[i_idx] <= {i_wr_slot, i_wr_pos};
        end
        r_rdata <= r_mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < MAX_VOICES; v++) begin
                r_active[v] <= 1'b0;
            end
            r_count <= '0;
        end else if (i_ctrl.stop) begin
            for (int v = 0; v < MAX_VOICES; v++) begin
                r_active[v] <= 1'b0;
            end
            r_count <= '0;
        end else if (i_ctrl.claim) begin
            r_active[i_idx] <= 1'b1;
            r_count         <= r_count + 1'b1;
        end else if (i_ctrl.release_v) begin
            r_active[i_idx] <= 1'b0;
            r_count         <= r_count - 1'b1;
        end
    end

    assign o_idx_active = r_active[i_idx];
    assign o_rd_slot    = r_rdata[SLW+PW-1:PW];
    assign o_rd_pos     = r_rdata[PW-1:0];
    assign o_count      = r_count;

endmodule

// ----- hw/rtl/mvsm_mac.sv -----
// Shared multiply-accumulate unit with the rounding and saturation of both channels.
module mvsm_mac
    import mvsm_pkg::*;
#(
    parameter int MAX_VOICES  = DEF_MAX_VOICES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic [2*SMP_W-1:0]       i_word,
    input  logic [VOL_W-1:0]         i_volume,
    output logic signed [SMP_W-1:0]  o_left,
    output logic signed [SMP_W-1:0]  o_right,
    output logic                     o_clipped
);

    // Each product fits 32 signed bits; the sum grows by the voice count.
    localparam int PRW = 2 * SMP_W;
    localparam int AW  = PRW + 1 + $clog2(MAX_VOICES);
    localparam int QW  = AW + 1 - VOL_FRAC;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));

    logic signed [PRW-1:0] r_prod;
    logic signed [AW-1:0]  r_acc_l;
    logic signed [AW-1:0]  r_acc_r;

    logic signed [SMP_W-1:0] mul_a;
    logic signed [PRW:0]     mul_full;
    logic [SAMPLE_BITS:0]    res_l;
    logic [SAMPLE_BITS:0]    res_r;
    logic signed [SAMPLE_BITS-1:0] sat_l;
    logic signed [SAMPLE_BITS-1:0] sat_r;

    function automatic logic [SAMPLE_BITS:0] scale_sat(input logic signed [AW-1:0] acc);
        logic signed [AW:0]            rnd;
        logic signed [QW-1:0]          q;
        logic signed [63:0]            q64;
        logic                          clip;
        logic [SAMPLE_BITS-1:0]        v;
        rnd  = $signed({acc[AW-1], acc}) + $signed((AW+1)'(RND_BIAS));
        q    = rnd[AW:VOL_FRAC];
        q64  = 64'(q);
        clip = 1'b0;
        if (q64 > SAT_HI) begin
            clip = 1'b1;
            v    = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q64 < SAT_LO) begin
            clip = 1'b1;
            v    = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            v    = q64[SAMPLE_BITS-1:0];
        end
        return {clip, v};
    endfunction

    assign mul_a    = i_ctrl.sel_right ? i_word[2*SMP_W-1:SMP_W] : i_word[SMP_W-1:0];
    assign mul_full = mul_a * $signed({1'b0, i_volume});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= mul_full[PRW-1:0];
        end
        if (i_ctrl.clear) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else begin
            if (i_ctrl.acc_left) begin
                r_acc_l <= r_acc_l + AW'(r_prod);
            end
            if (i_ctrl.acc_right) begin
                r_acc_r <= r_acc_r + AW'(r_prod);
            end
        end
    end

    assign res_l = scale_sat(r_acc_l);
    assign res_r = scale_sat(r_acc_r);
    assign sat_l = res_l[SAMPLE_BITS-1:0];
    assign sat_r = res_r[SAMPLE_BITS-1:0];

    assign o_left    = SMP_W'(sat_l);
    assign o_right   = SMP_W'(sat_r);
    assign o_clipped = res_l[SAMPLE_BITS] | res_r[SAMPLE_BITS];

endmodule

// ----- hw/rtl/multi_voice_sample_mixer.sv -----
// Polyphonic stereo sample playback mixer: top level with the command sequencer.
//
// One item is taken at a time and gives one result. A tick walks the voices in order
// through one shared multiplier: an idle voice is skipped, and a playing voice passes
// through table read, sample read, left product, right product and last accumulate.
// A play command searches for the lowest free voice one per cycle. After reset the slot
// length memory is cleared at one slot a cycle, and no item is taken until the clearing
// is done; configuration writes are taken at any time. Sample words read before they
// are written return unknown data.
module multi_voice_sample_mixer
    import mvsm_pkg::*;
#(
    parameter int NUM_SOUNDS  = DEF_NUM_SOUNDS,
    parameter int SOUND_WORDS = DEF_SOUND_WORDS,
    parameter int MAX_VOICES  = DEF_MAX_VOICES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_cmd,
    input  logic [3:0]                 i_sound_index,
    input  logic                       i_alt_copy,
    input  logic [11:0]                i_sample_addr,
    input  logic signed [SMP_W-1:0]    i_sample_left,
    input  logic signed [SMP_W-1:0]    i_sample_right,
    input  logic [12:0]                i_sound_length,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SMP_W-1:0]    o_left_out,
    output logic signed [SMP_W-1:0]    o_right_out,
    output logic [ACTIVE_W-1:0]        o_active_voices,
    output logic                       o_buffer_last,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [VOL_W-1:0]           i_cfg_data
);

    localparam int SLW  = $clog2(2 * NUM_SOUNDS);
    localparam int PW   = $clog2(SOUND_WORDS);
    localparam int LW   = $clog2(SOUND_WORDS + 1);
    localparam int VW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNTW = $clog2(MAX_VOICES + 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PLAY_CHK = 9'b000000010,
        ST_FIND     = 9'b000000100,
        ST_SCAN     = 9'b000001000,
        ST_FETCH    = 9'b000010000,
        ST_MUL_L    = 9'b000100000,
        ST_MUL_R    = 9'b001000000,
        ST_ACC_R    = 9'b010000000,
        ST_DONE     = 9'b100000000
    } t_state;

    t_state             r_state,  n_state;
    logic [CNTW-1:0]    r_vcnt,   n_vcnt;
    logic [SLW-1:0]     r_slot,   n_slot;
    logic               r_snd_ok, n_snd_ok;
    logic               r_tick,   n_tick;
    t_status            r_status, n_status;
    logic               r_last,   n_last;
    logic [FRAME_W-1:0] r_frame,  n_frame;
    logic [VOL_W-1:0]   r_volume;
    logic [FPB_W-1:0]   r_fpb;

    logic                    r_out_valid, n_out_valid;
    logic signed [SMP_W-1:0] r_left,  n_left;
    logic signed [SMP_W-1:0] r_right, n_right;
    logic [ACTIVE_W-1:0]     r_active, n_active;
    logic                    r_blast, n_blast;
    logic [1:0]              r_stat_out, n_stat_out;

    logic            in_fire;
    logic [SLW-1:0]  in_slot;
    logic            snd_ok;
    logic            addr_ok;
    logic [LW-1:0]   len_sat;
    logic [FPB_W-1:0] fpb_eff;
    logic            out_free;

    t_mem_ctrl       mem_ctrl;
    t_voice_ctrl     vt_ctrl;
    t_mac_ctrl       mac_ctrl;

    logic [SLW-1:0]  sm_rd_slot;
    logic [2*SMP_W-1:0] sm_word;
    logic [LW-1:0]   sm_len;
    logic            sm_busy;

    logic [VW-1:0]   vt_idx;
    logic [SLW-1:0]  vt_wr_slot;
    logic [PW-1:0]   vt_wr_pos;
    logic            vt_idx_active;
    logic [SLW-1:0]  vt_slot;
    logic [PW-1:0]   vt_pos;
    logic [CNTW-1:0] vt_count;
    logic [PW:0]     pos_next;

    logic signed [SMP_W-1:0] mac_left;
    logic signed [SMP_W-1:0] mac_right;
    logic                    mac_clipped;

    assign o_in_ready = (r_state == ST_IDLE) && !sm_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign in_slot = SLW'({i_sound_index, i_alt_copy});
    assign snd_ok  = int'(i_sound_index) < NUM_SOUNDS;
    assign addr_ok = int'(i_sample_addr) < SOUND_WORDS;
    assign len_sat = (int'(i_sound_length) > SOUND_WORDS) ? LW'(SOUND_WORDS)
                                                          : LW'(i_sound_length);

    // Buffer length zero counts as one and anything above the maximum as the maximum.
    assign fpb_eff = (r_fpb == '0)     ? FPB_W'(1) :
                     (r_fpb > FPB_MAX) ? FPB_MAX   : r_fpb;

    assign vt_idx   = r_vcnt[VW-1:0];
    assign pos_next = {1'b0, vt_pos} + 1'b1;

    always_comb begin
        mem_ctrl.rd     = in_fire || (r_state == ST_FETCH);
        mem_ctrl.smp_wr = in_fire && (i_cmd == CMD_WRITE) && snd_ok && addr_ok;
        mem_ctrl.len_wr = in_fire && (i_cmd == CMD_LENGTH) && snd_ok;
        sm_rd_slot      = (r_state == ST_FETCH) ? vt_slot : in_slot;
    end

    always_comb begin
        n_state     = r_state;
        n_vcnt      = r_vcnt;
        n_slot      = r_slot;
        n_snd_ok    = r_snd_ok;
        n_tick      = r_tick;
        n_status    = r_status;
        n_last      = r_last;
        n_frame     = r_frame;
        n_out_valid = r_out_valid && !i_out_ready;
        n_left      = r_left;
        n_right     = r_right;
        n_active    = r_active;
        n_blast     = r_blast;
        n_stat_out  = r_stat_out;

        vt_ctrl    = '0;
        vt_wr_slot = vt_slot;
        vt_wr_pos  = PW'(pos_next);
        mac_ctrl   = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_vcnt         = '0;
                    n_slot         = in_slot;
                    n_snd_ok       = snd_ok;
                    n_tick         = (i_cmd == CMD_TICK);
                    n_status       = STAT_OK;
                    n_last         = 1'b0;
                    mac_ctrl.clear = 1'b1;
                    case (i_cmd)
                        CMD_TICK: begin
                            if (({1'b0, r_frame} + 1'b1) >= fpb_eff) begin
                                n_last  = 1'b1;
                                n_frame = '0;
                            end else begin
                                n_frame = r_frame + 1'b1;
                            end
                            n_state = ST_SCAN;
                        end
                        CMD_PLAY: begin
                            n_state = ST_PLAY_CHK;
                        end
                        CMD_STOP: begin
                            vt_ctrl.stop = 1'b1;
                            n_state      = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PLAY_CHK: begin
                // Out-of-range sounds and empty slots are dropped and report STAT_OK.
                if (!r_snd_ok || (sm_len == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                vt_wr_slot = r_slot;
                vt_wr_pos  = '0;
                if (r_vcnt == CNTW'(MAX_VOICES)) begin
                    n_status = STAT_FULL;
                    n_state  = ST_DONE;
                end else if (!vt_idx_active) begin
                    vt_ctrl.claim = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    n_vcnt = r_vcnt + 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_vcnt == CNTW'(MAX_VOICES)) begin
                    n_state = ST_DONE;
                end else if (vt_idx_active) begin
                    n_state = ST_FETCH;
                end else begin
                    n_vcnt = r_vcnt + 1'b1;
                end
            end
            ST_FETCH: begin
                n_state = ST_MUL_L;
            end
            ST_MUL_L: begin
                // The voice steps on and frees itself once it reaches the slot length.
                vt_ctrl.advance   = 1'b1;
                vt_ctrl.release_v = (pos_next >= (PW+1)'(sm_len));
                mac_ctrl.mul      = 1'b1;
                n_state           = ST_MUL_R;
            end
            ST_MUL_R: begin
                mac_ctrl.acc_left  = 1'b1;
                mac_ctrl.mul       = 1'b1;
                mac_ctrl.sel_right = 1'b1;
                n_state            = ST_ACC_R;
            end
            ST_ACC_R: begin
                mac_ctrl.acc_right = 1'b1;
                n_vcnt             = r_vcnt + 1'b1;
                n_state            = ST_SCAN;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_left      = mac_left;
                    n_right     = mac_right;
                    n_active    = ACTIVE_W'(vt_count);
                    n_blast     = r_last;
                    n_stat_out  = (r_tick && mac_clipped) ? STAT_CLIP : r_status;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
            r_volume    <= VOLUME_RESET;
            r_fpb       <= FPB_RESET;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VOLUME: r_volume <= i_cfg_data;
                    CFG_FPB:    r_fpb    <= i_cfg_data[FPB_W-1:0];
                    default:    r_fpb    <= r_fpb;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vcnt     <= n_vcnt;
        r_slot     <= n_slot;
        r_snd_ok   <= n_snd_ok;
        r_tick     <= n_tick;
        r_status   <= n_status;
        r_last     <= n_last;
        r_left     <= n_left;
        r_right    <= n_right;
        r_active   <= n_active;
        r_blast    <= n_blast;
        r_stat_out <= n_stat_out;
    end

    mvsm_sample_mem #(
        .NUM_SOUNDS  (NUM_SOUNDS),
        .SOUND_WORDS (SOUND_WORDS)
    ) u_sample_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (mem_ctrl),
        .i_wr_slot   (in_slot),
        .i_wr_pos    (PW'(i_sample_addr)),
        .i_smp_wdata ({i_sample_right, i_sample_left}),
        .i_len_wdata (len_sat),
        .i_rd_slot   (sm_rd_slot),
        .i_rd_pos    (vt_pos),
        .o_smp_rdata (sm_word),
        .o_len_rdata (sm_len),
        .o_busy      (sm_busy)
    );

    mvsm_voice_tbl #(
        .NUM_SOUNDS  (NUM_SOUNDS),
        .SOUND_WORDS (SOUND_WORDS),
        .MAX_VOICES  (MAX_VOICES)
    ) u_voice_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (vt_ctrl),
        .i_idx        (vt_idx),
        .i_wr_slot    (vt_wr_slot),
        .i_wr_pos     (vt_wr_pos),
        .o_idx_active (vt_idx_active),
        .o_rd_slot    (vt_slot),
        .o_rd_pos     (vt_pos),
        .o_count      (vt_count)
    );

    mvsm_mac #(
        .MAX_VOICES  (MAX_VOICES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (mac_ctrl),
        .i_word    (sm_word),
        .i_volume  (r_volume),
        .o_left    (mac_left),
        .o_right   (mac_right),
        .o_clipped (mac_clipped)
    );

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_left;
    assign o_right_out     = r_right;
    assign o_active_voices = r_active;
    assign o_buffer_last   = r_blast;
    assign o_status        = r_stat_out;
    assign o_cfg_ready     = 1'b1;

endmodule
